FILE: hw/rtl/i2cra_pkg.sv
// Package: types and codes shared by the I2C register access master.
package i2cra_pkg;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_START_HI,
      PH_START_LO,
      PH_TX_LOW,
      PH_TX_HIGH,
      PH_TXACK_LOW,
      PH_TXACK_HIGH,
      PH_RESTART_LOW,
      PH_RX_LOW,
      PH_RX_HIGH,
      PH_RXACK_LOW,
      PH_RXACK_HIGH,
      PH_STOP_A,
      PH_STOP_B,
      PH_STOP_C
   } phase_type;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic CSR_HALF_PERIOD    = 1'b1;

   typedef struct packed {
      logic        advance;
      logic [1:0]  kind;
      logic [7:0]  reg_index;
      logic [15:0] write_value;
      logic        sda_in;
   } step_type;

   typedef struct packed {
      logic        read_done;
      logic [15:0] read_value;
      logic        busy_res;
      logic        sda_release;
      logic        scl_level;
   } result_type;

endpackage

FILE: hw/rtl/i2c_register_access_master.sv
// Top level: I2C 16-bit register access master with stream handshake and CSR port.
//
//   channel | dir | handshake             | payload
//   req     | in  | req_tvalid/req_tready | tuser kind, tdata reg/value/sda_in
//   rsp     | out | rsp_tvalid/rsp_tready | tdata scl, sda, busy, read value, done
//   csr     | in  | csr_valid/csr_ready   | csr_index, csr_data
//
// One transfer per cycle unless rsp stalls; its result is valid in the next cycle.
// The sequencer state is one register set updated by a single combinational step.
// A stalled rsp holds its result and blocks req only while it is not taken.
// Reset (synchronous) returns the bus to idle and the registers to address 17,
// half period 50 ticks. csr_ready is always high.
module i2c_register_access_master
   import i2cra_pkg::*;
#(
   parameter int DELAY_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // reg_index[7:0], write_value[23:8], sda_in[24]
   input  logic [1:0]  req_tuser,  // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // scl_level[0], sda_release[1], busy_res[2],
                                   // read_value[18:3], read_done[19]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   localparam int LW = (DELAY_BITS > 16) ? DELAY_BITS : 16;

   logic [6:0]            device_address_ff;
   logic [15:0]           half_period_ff;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   result_type            rsp_data_ff;
   result_type            result;
   step_type              step;
   logic [DELAY_BITS-1:0] phase_len;
   logic [LW-1:0]         hp_w;
   logic [LW-1:0]         cap_w;
   logic [LW-1:0]         len_w;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_tvalid_ff || rsp_tready;

   assign hp_w      = LW'(half_period_ff);
   assign cap_w     = LW'({DELAY_BITS{1'b1}});
   assign len_w     = (hp_w == '0) ? LW'(1) : ((hp_w > cap_w) ? cap_w : hp_w);
   assign phase_len = len_w[DELAY_BITS-1:0];

   always_comb begin
      step.advance     = req_tvalid && req_tready;
      step.kind        = req_tuser;
      step.reg_index   = req_tdata[7:0];
      step.write_value = req_tdata[23:8];
      step.sda_in      = req_tdata[24];
   end

   i2cra_seq #(
      .DELAY_BITS(DELAY_BITS)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .device_address (device_address_ff),
      .phase_len      (phase_len),
      .result         (result)
   );

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (step.advance) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff     <= 1'b0;
         device_address_ff <= 7'd17;
         half_period_ff    <= 16'd50;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_DEVICE_ADDRESS: device_address_ff <= csr_data[6:0];
               CSR_HALF_PERIOD:    half_period_ff    <= csr_data;
               default:            half_period_ff    <= half_period_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step.advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {4'd0, rsp_data_ff};

`ifndef SYNTH
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_data_ff.read_done |-> rsp_data_ff.busy_res)
      else $error("read_done without busy");

   a_idle_bus: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && !rsp_data_ff.busy_res |->
         rsp_data_ff.scl_level && rsp_data_ff.sda_release)
      else $error("idle result does not release the bus");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && !rsp_tready |-> !req_tready)
      else $error("request taken while result stalled");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && !rsp_tready |=> rsp_tvalid_ff && $stable(rsp_data_ff))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid_ff)
      else $error("result valid after reset");
`endif

endmodule

FILE: hw/rtl/i2cra_seq.sv
// Bus sequencer: phase state, bit/byte counters and shift registers, one step per transfer.
module i2cra_seq
   import i2cra_pkg::*;
#(
   parameter int DELAY_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  step_type              step,
   input  logic [6:0]            device_address,
   input  logic [DELAY_BITS-1:0] phase_len,
   output result_type            result
);

   phase_type             phase_ff, phase_in;
   logic [2:0]            bit_count_ff, bit_count_in;
   logic [2:0]            byte_count_ff, byte_count_in;
   logic [7:0]            shift_byte_ff, shift_byte_in;
   logic [DELAY_BITS-1:0] tick_count_ff, tick_count_in;
   logic [7:0]            held_register_ff, held_register_in;
   logic [15:0]           held_value_ff, held_value_in;
   logic                  is_read_ff, is_read_in;
   logic [15:0]           received_value_ff, received_value_in;

   function automatic logic [7:0] tx_byte(input logic [2:0] n, input logic [6:0] addr,
                                          input logic rd, input logic [7:0] regi,
                                          input logic [15:0] val);
      logic [7:0] b;
      unique case (n)
         3'd0:    b = {addr, 1'b0};
         3'd1:    b = regi;
         3'd2:    b = rd ? {addr, 1'b1} : val[15:8];
         default: b = val[7:0];
      endcase
      return b;
   endfunction

   always_comb begin
      logic [DELAY_BITS-1:0] tick_inc;
      logic [2:0]            byte_next;
      logic                  scl;
      logic                  sda;
      logic                  busy;
      logic                  done;

      phase_in          = phase_ff;
      bit_count_in      = bit_count_ff;
      byte_count_in     = byte_count_ff;
      shift_byte_in     = shift_byte_ff;
      tick_count_in     = tick_count_ff;
      held_register_in  = held_register_ff;
      held_value_in     = held_value_ff;
      is_read_in        = is_read_ff;
      received_value_in = received_value_ff;
      done              = 1'b0;

      if (phase_ff == PH_IDLE && (step.kind == KIND_WRITE || step.kind == KIND_READ)) begin
         is_read_in       = (step.kind == KIND_READ);
         held_register_in = step.reg_index;
         held_value_in    = (step.kind == KIND_READ) ? 16'd0 : step.write_value;
         byte_count_in    = 3'd0;
         bit_count_in     = 3'd0;
         tick_count_in    = '0;
         shift_byte_in    = {device_address, 1'b0};
         phase_in         = PH_START_HI;
      end

      unique case (phase_in)
         PH_START_HI:    begin scl = 1'b1; sda = 1'b1; end
         PH_START_LO:    begin scl = 1'b1; sda = 1'b0; end
         PH_TX_LOW:      begin scl = 1'b0; sda = shift_byte_in[7]; end
         PH_TX_HIGH:     begin scl = 1'b1; sda = shift_byte_in[7]; end
         PH_TXACK_LOW:   begin scl = 1'b0; sda = 1'b1; end
         PH_RESTART_LOW: begin scl = 1'b0; sda = 1'b1; end
         PH_RX_LOW:      begin scl = 1'b0; sda = 1'b1; end
         PH_RXACK_LOW:   begin scl = 1'b0; sda = (byte_count_in != 3'd3); end
         PH_RXACK_HIGH:  begin scl = 1'b1; sda = (byte_count_in != 3'd3); end
         PH_STOP_A:      begin scl = 1'b0; sda = 1'b0; end
         PH_STOP_B:      begin scl = 1'b1; sda = 1'b0; end
         default:        begin scl = 1'b1; sda = 1'b1; end
      endcase

      busy      = (phase_in != PH_IDLE);
      tick_inc  = tick_count_in + 1'b1;
      byte_next = byte_count_in + 3'd1;

      if (!busy) begin
         tick_count_in = '0;
      end else if (tick_inc >= phase_len || tick_inc == '0) begin
         tick_count_in = '0;
         unique case (phase_in)
            PH_START_HI: phase_in = PH_START_LO;
            PH_START_LO: begin
               bit_count_in = 3'd0;
               phase_in     = PH_TX_LOW;
            end
            PH_TX_LOW: phase_in = PH_TX_HIGH;
            PH_TX_HIGH: begin
               if (bit_count_in == 3'd7) begin
                  bit_count_in = 3'd0;
                  phase_in     = PH_TXACK_LOW;
               end else begin
                  bit_count_in  = bit_count_in + 3'd1;
                  shift_byte_in = {shift_byte_in[6:0], 1'b0};
                  phase_in      = PH_TX_LOW;
               end
            end
            PH_TXACK_LOW: phase_in = PH_TXACK_HIGH;
            PH_TXACK_HIGH: begin
               byte_count_in = byte_next;
               bit_count_in  = 3'd0;
               if (is_read_in) begin
                  if (byte_next == 3'd2) begin
                     shift_byte_in = {device_address, 1'b1};
                     phase_in      = PH_RESTART_LOW;
                  end else if (byte_next >= 3'd3) begin
                     held_value_in = 16'd0;
                     phase_in      = PH_RX_LOW;
                  end else begin
                     shift_byte_in = tx_byte(byte_next, device_address, is_read_in,
                                             held_register_in, held_value_in);
                     phase_in      = PH_TX_LOW;
                  end
               end else if (byte_next >= 3'd4) begin
                  phase_in = PH_STOP_A;
               end else begin
                  shift_byte_in = tx_byte(byte_next, device_address, is_read_in,
                                          held_register_in, held_value_in);
                  phase_in      = PH_TX_LOW;
               end
            end
            PH_RESTART_LOW: phase_in = PH_START_HI;
            PH_RX_LOW:      phase_in = PH_RX_HIGH;
            PH_RX_HIGH: begin
               held_value_in = {held_value_in[14:0], step.sda_in};
               if (bit_count_in == 3'd7) begin
                  bit_count_in = 3'd0;
                  phase_in     = PH_RXACK_LOW;
               end else begin
                  bit_count_in = bit_count_in + 3'd1;
                  phase_in     = PH_RX_LOW;
               end
            end
            PH_RXACK_LOW: phase_in = PH_RXACK_HIGH;
            PH_RXACK_HIGH: begin
               byte_count_in = byte_next;
               bit_count_in  = 3'd0;
               phase_in      = (byte_next == 3'd4) ? PH_RX_LOW : PH_STOP_A;
            end
            PH_STOP_A: phase_in = PH_STOP_B;
            PH_STOP_B: phase_in = PH_STOP_C;
            PH_STOP_C: begin
               if (is_read_in) begin
                  received_value_in = held_value_in;
                  done              = 1'b1;
               end
               phase_in = PH_IDLE;
            end
            default: phase_in = PH_IDLE;
         endcase
      end else begin
         tick_count_in = tick_inc;
      end

      result.scl_level   = scl;
      result.sda_release = sda;
      result.busy_res    = busy;
      result.read_value  = received_value_in;
      result.read_done   = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         bit_count_ff      <= '0;
         byte_count_ff     <= '0;
         shift_byte_ff     <= '0;
         tick_count_ff     <= '0;
         held_register_ff  <= '0;
         held_value_ff     <= '0;
         is_read_ff        <= 1'b0;
         received_value_ff <= '0;
      end else if (step.advance) begin
         phase_ff          <= phase_in;
         bit_count_ff      <= bit_count_in;
         byte_count_ff     <= byte_count_in;
         shift_byte_ff     <= shift_byte_in;
         tick_count_ff     <= tick_count_in;
         held_register_ff  <= held_register_in;
         held_value_ff     <= held_value_in;
         is_read_ff        <= is_read_in;
         received_value_ff <= received_value_in;
      end
   end

endmodule
